// ===== rtl/core/hcaj_pkg.sv =====
package hcaj_pkg;

    // field widths fixed by the interface
    localparam int unsigned HASH_W    = 64;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned SEQ_OUT_W = 11;
    localparam int unsigned RSEQ_W    = 12;

    // hashed message: sequence, input digest, result digest, previous head
    localparam int unsigned MSG_WORDS = 4;
    localparam int unsigned MSG_W     = MSG_WORDS * HASH_W;
    localparam int unsigned MSG_BYTES = MSG_W / BYTE_W;
    localparam int unsigned BCNT_W    = $clog2(MSG_BYTES);

    localparam logic [HASH_W-1:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;

    typedef enum logic {
        REQ_APPEND = 1'b0,
        REQ_READ   = 1'b1
    } req_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BAD_SEQ  = 2'd2,
        ST_MISMATCH = 2'd3
    } status_t;

    typedef struct packed {
        logic [HASH_W-1:0] input_digest;
        logic [HASH_W-1:0] result_digest;
        logic [HASH_W-1:0] prior_hash;
        logic [HASH_W-1:0] record_hash;
    } record_t;

    // one fnv-1a round; the prime is 2^40 + 0x1b3, so the product is a sum of shifts
    function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                   input logic [BYTE_W-1:0] b);
        logic [HASH_W-1:0] x;
        x = h ^ {{(HASH_W-BYTE_W){1'b0}}, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

// ===== rtl/core/hcaj_store.sv =====
module hcaj_store import hcaj_pkg::*; #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  record_t       wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output record_t       rd_data
);

    record_t mem [DEPTH];
    record_t rd_data_reg;

    // single write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/hcaj_fnv.sv =====
module hcaj_fnv import hcaj_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [MSG_W-1:0]  msg,
    output logic              done,
    output logic [HASH_W-1:0] hash
);

    logic [MSG_W-1:0]  msg_reg, msg_next;
    logic [HASH_W-1:0] h_reg, h_next;
    logic [BCNT_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              last_byte;

    assign last_byte = (cnt_reg == BCNT_W'(MSG_BYTES - 1));

    // one byte per cycle, lowest byte of the shift register first
    always_comb begin
        msg_next  = msg_reg;
        h_next    = h_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            msg_next  = msg;
            h_next    = FNV_BASIS;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            h_next   = fnv_step(h_reg, msg_reg[BYTE_W-1:0]);
            msg_next = msg_reg >> BYTE_W;
            cnt_next = cnt_reg + 1'b1;
            if (last_byte) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        msg_reg <= msg_next;
        h_reg   <= h_next;
    end

    // a zero hash is reported as one
    assign done = done_reg;
    assign hash = (h_reg == '0) ? HASH_W'(1) : h_reg;

endmodule

// ===== rtl/core/hash_chained_append_journal.sv =====
// append and read results wait on the byte-serial fnv unit, which folds one of the 32
//   message bytes per cycle; a read first fetches the stored record
// full journal or bad sequence: no hashing; the sequencer goes straight to S_FINISH
// throughput: one item at a time; the next is taken the cycle after the result is
//   registered, while that result may still wait on m_ready
// reset: aresetn (synchronous, active low) empties the journal; memory is not cleared
module hash_chained_append_journal import hcaj_pkg::*; #(
    parameter int unsigned DEPTH = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_req_type,
    input  logic [HASH_W-1:0]    s_input_digest,
    input  logic [HASH_W-1:0]    s_result_digest,
    input  logic [RSEQ_W-1:0]    s_read_sequence,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_status,
    output logic [SEQ_OUT_W-1:0] m_seq_number,
    output logic [HASH_W-1:0]    m_record_hash,
    output logic [HASH_W-1:0]    m_prior_hash,
    output logic [HASH_W-1:0]    m_stored_input_digest,
    output logic [HASH_W-1:0]    m_stored_result_digest,
    output logic [SEQ_OUT_W-1:0] m_entry_total,
    output logic [HASH_W-1:0]    m_head_hash
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned SW = (CW > RSEQ_W) ? CW : RSEQ_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_HASH,
        S_FINISH
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [HASH_W-1:0] head_reg, head_next;
    logic              is_read_reg, is_read_next;
    logic              start_reg, start_next;

    // working record of the item in flight
    status_t           st_reg, st_next;
    logic [CW-1:0]     seq_reg, seq_next;
    logic [HASH_W-1:0] rhash_reg, rhash_next;
    logic [HASH_W-1:0] prior_reg, prior_next;
    logic [HASH_W-1:0] sin_reg, sin_next;
    logic [HASH_W-1:0] sres_reg, sres_next;

    // result register
    logic                 m_valid_reg, m_valid_next;
    status_t              m_status_reg, m_status_next;
    logic [SEQ_OUT_W-1:0] m_seq_reg, m_seq_next;
    logic [HASH_W-1:0]    m_rhash_reg, m_rhash_next;
    logic [HASH_W-1:0]    m_prior_reg, m_prior_next;
    logic [HASH_W-1:0]    m_sin_reg, m_sin_next;
    logic [HASH_W-1:0]    m_sres_reg, m_sres_next;
    logic [SEQ_OUT_W-1:0] m_total_reg, m_total_next;
    logic [HASH_W-1:0]    m_head_reg, m_head_next;

    logic              in_xfer;
    logic [SW-1:0]     rs_ext;
    logic              mem_wr_en, mem_rd_en;
    logic [AW-1:0]     mem_wr_addr, mem_rd_addr;
    record_t           mem_wr_data, mem_rd_data;
    logic              hash_done;
    logic [HASH_W-1:0] hash_value;
    logic [MSG_W-1:0]  hash_msg;

    assign s_ready = (state_reg == S_IDLE);
    assign in_xfer = s_valid && s_ready;
    assign rs_ext  = SW'(s_read_sequence);

    // sequence word goes out first, lowest byte first
    assign hash_msg = {prior_reg, sres_reg, sin_reg, HASH_W'(seq_reg)};

    assign mem_wr_addr = AW'(seq_reg - 1'b1);
    assign mem_wr_data = '{input_digest:  sin_reg,
                           result_digest: sres_reg,
                           prior_hash:    prior_reg,
                           record_hash:   hash_value};
    assign mem_rd_addr = AW'(rs_ext - 1'b1);

    hcaj_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    hcaj_fnv u_fnv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_reg),
        .msg     (hash_msg),
        .done    (hash_done),
        .hash    (hash_value)
    );

    // sequencer: accept, fetch, hash, commit, hand over to the result register
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        head_next    = head_reg;
        is_read_next = is_read_reg;
        start_next   = 1'b0;
        st_next      = st_reg;
        seq_next     = seq_reg;
        rhash_next   = rhash_reg;
        prior_next   = prior_reg;
        sin_next     = sin_reg;
        sres_next    = sres_reg;
        mem_wr_en    = 1'b0;
        mem_rd_en    = 1'b0;

        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_seq_next    = m_seq_reg;
        m_rhash_next  = m_rhash_reg;
        m_prior_next  = m_prior_reg;
        m_sin_next    = m_sin_reg;
        m_sres_next   = m_sres_reg;
        m_total_next  = m_total_reg;
        m_head_next   = m_head_reg;

        case (state_reg)
            S_IDLE: begin
                if (in_xfer) begin
                    st_next    = ST_OK;
                    seq_next   = '0;
                    rhash_next = '0;
                    prior_next = '0;
                    sin_next   = '0;
                    sres_next  = '0;
                    if (req_t'(s_req_type) == REQ_APPEND) begin
                        is_read_next = 1'b0;
                        if (count_reg == CW'(DEPTH)) begin
                            st_next    = ST_FULL;
                            state_next = S_FINISH;
                        end else begin
                            seq_next   = count_reg + 1'b1;
                            sin_next   = s_input_digest;
                            sres_next  = s_result_digest;
                            prior_next = head_reg;
                            start_next = 1'b1;
                            state_next = S_HASH;
                        end
                    end else begin
                        is_read_next = 1'b1;
                        if (rs_ext == '0 || rs_ext > SW'(count_reg)) begin
                            st_next    = ST_BAD_SEQ;
                            state_next = S_FINISH;
                        end else begin
                            mem_rd_en  = 1'b1;
                            seq_next   = CW'(rs_ext);
                            state_next = S_FETCH;
                        end
                    end
                end
            end

            S_FETCH: begin
                sin_next   = mem_rd_data.input_digest;
                sres_next  = mem_rd_data.result_digest;
                prior_next = mem_rd_data.prior_hash;
                rhash_next = mem_rd_data.record_hash;
                start_next = 1'b1;
                state_next = S_HASH;
            end

            S_HASH: begin
                if (hash_done) begin
                    if (is_read_reg) begin
                        if (hash_value != rhash_reg) begin
                            st_next  = ST_MISMATCH;
                            seq_next = '0;
                        end
                    end else begin
                        // commit the new record and move the head
                        mem_wr_en  = 1'b1;
                        rhash_next = hash_value;
                        count_next = seq_reg;
                        head_next  = hash_value;
                    end
                    state_next = S_FINISH;
                end
            end

            S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = st_reg;
                    m_seq_next    = SEQ_OUT_W'(seq_reg);
                    m_rhash_next  = rhash_reg;
                    m_prior_next  = prior_reg;
                    m_sin_next    = sin_reg;
                    m_sres_next   = sres_reg;
                    m_total_next  = SEQ_OUT_W'(count_reg);
                    m_head_next   = head_reg;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            head_reg    <= '0;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            head_reg    <= head_next;
            start_reg   <= start_next;
            m_valid_reg <= m_valid_next;
        end
        is_read_reg  <= is_read_next;
        st_reg       <= st_next;
        seq_reg      <= seq_next;
        rhash_reg    <= rhash_next;
        prior_reg    <= prior_next;
        sin_reg      <= sin_next;
        sres_reg     <= sres_next;
        m_status_reg <= m_status_next;
        m_seq_reg    <= m_seq_next;
        m_rhash_reg  <= m_rhash_next;
        m_prior_reg  <= m_prior_next;
        m_sin_reg    <= m_sin_next;
        m_sres_reg   <= m_sres_next;
        m_total_reg  <= m_total_next;
        m_head_reg   <= m_head_next;
    end

    assign m_valid                = m_valid_reg;
    assign m_status               = m_status_reg;
    assign m_seq_number           = m_seq_reg;
    assign m_record_hash          = m_rhash_reg;
    assign m_prior_hash           = m_prior_reg;
    assign m_stored_input_digest  = m_sin_reg;
    assign m_stored_result_digest = m_sres_reg;
    assign m_entry_total          = m_total_reg;
    assign m_head_hash            = m_head_reg;

`ifndef SYNTHESIS
    // the record count never passes the journal depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("record count above depth");

    // a non-empty journal always has a non-zero head
    a_head_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != '0) |-> (head_reg != '0))
        else $error("zero head with records present");

    // the hash unit only finishes while the sequencer waits for it
    a_done_in_hash: assert property (@(posedge aclk) disable iff (!aresetn)
        hash_done |-> (state_reg == S_HASH))
        else $error("hash finished outside hash state");

    // memory write and read never share a cycle
    a_port_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_wr_en && mem_rd_en))
        else $error("memory read and write in the same cycle");
`endif

endmodule

// ===== tb/hash_chained_append_journal_tb.sv =====
module hash_chained_append_journal_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hcaj_pkg::*;

    localparam int unsigned JOURNAL_DEPTH = 1024;
    localparam logic [HASH_W-1:0] FNV_PRIME = 64'h0000_0100_0000_01B3;
    localparam int unsigned RANDOM_ITEMS = 1800;
    localparam int unsigned CHUNK_ITEMS = 300;
    localparam int unsigned DRAIN_CYCLES = 60;
    // 1816 items in all, each slowed by the byte-serial hash, driver gaps and a slow sink
    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    typedef struct {
        req_t              kind;
        logic [HASH_W-1:0] in_digest;
        logic [HASH_W-1:0] res_digest;
        logic [RSEQ_W-1:0] rd_seq;
    } journal_req_t;

    typedef struct {
        status_t              status;
        logic [SEQ_OUT_W-1:0] seq;
        logic [HASH_W-1:0]    rec_hash;
        logic [HASH_W-1:0]    prior;
        logic [HASH_W-1:0]    stored_in;
        logic [HASH_W-1:0]    stored_res;
        logic [SEQ_OUT_W-1:0] total;
        logic [HASH_W-1:0]    head;
    } journal_resp_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_req_type = 1'b0;
    logic [HASH_W-1:0]    s_input_digest = '0;
    logic [HASH_W-1:0]    s_result_digest = '0;
    logic [RSEQ_W-1:0]    s_read_sequence = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [1:0]           m_status;
    logic [SEQ_OUT_W-1:0] m_seq_number;
    logic [HASH_W-1:0]    m_record_hash;
    logic [HASH_W-1:0]    m_prior_hash;
    logic [HASH_W-1:0]    m_stored_input_digest;
    logic [HASH_W-1:0]    m_stored_result_digest;
    logic [SEQ_OUT_W-1:0] m_entry_total;
    logic [HASH_W-1:0]    m_head_hash;

    // shadow journal state
    int unsigned       jrnl_count = 0;
    logic [HASH_W-1:0] jrnl_head = '0;
    logic [HASH_W-1:0] jrnl_in_mem [JOURNAL_DEPTH];
    logic [HASH_W-1:0] jrnl_res_mem [JOURNAL_DEPTH];
    logic [HASH_W-1:0] jrnl_prior_mem [JOURNAL_DEPTH];
    logic [HASH_W-1:0] jrnl_hash_mem [JOURNAL_DEPTH];

    journal_req_t  pending_requests[$];
    journal_resp_t expected_responses[$];
    int unsigned   mismatch_count = 0;
    int unsigned   cycle_count = 0;
    // appends queued so far, saturating at the depth; steers read sequences
    int unsigned   queued_appends = 0;

    hash_chained_append_journal #(
        .DEPTH(JOURNAL_DEPTH)
    ) u_top (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_req_type             (s_req_type),
        .s_input_digest         (s_input_digest),
        .s_result_digest        (s_result_digest),
        .s_read_sequence        (s_read_sequence),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_status               (m_status),
        .m_seq_number           (m_seq_number),
        .m_record_hash          (m_record_hash),
        .m_prior_hash           (m_prior_hash),
        .m_stored_input_digest  (m_stored_input_digest),
        .m_stored_result_digest (m_stored_result_digest),
        .m_entry_total          (m_entry_total),
        .m_head_hash            (m_head_hash)
    );

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // fnv-1a 64 over sequence, input digest, result digest, previous head; lsb first
    function automatic logic [HASH_W-1:0] record_digest(input logic [HASH_W-1:0] seq,
                                                        input logic [HASH_W-1:0] in_dig,
                                                        input logic [HASH_W-1:0] res_dig,
                                                        input logic [HASH_W-1:0] prev);
        logic [HASH_W-1:0] words [4];
        logic [HASH_W-1:0] h;
        words = '{seq, in_dig, res_dig, prev};
        h = FNV_BASIS;
        for (int w = 0; w < 4; w++) begin
            for (int b = 0; b < 8; b++) begin
                h = (h ^ ((words[w] >> (8 * b)) & 64'hFF)) * FNV_PRIME;
            end
        end
        return (h == '0) ? 64'd1 : h;
    endfunction

    // apply one request to the shadow journal and return the response it should give
    function automatic journal_resp_t journal_apply(input journal_req_t req);
        journal_resp_t rsp;
        int unsigned   idx;
        rsp = '{ST_OK, '0, '0, '0, '0, '0, '0, '0};
        if (req.kind == REQ_APPEND) begin
            if (jrnl_count >= JOURNAL_DEPTH) begin
                rsp.status = ST_FULL;
            end else begin
                idx = jrnl_count;
                rsp.seq = SEQ_OUT_W'(jrnl_count + 1);
                rsp.stored_in = req.in_digest;
                rsp.stored_res = req.res_digest;
                rsp.prior = jrnl_head;
                rsp.rec_hash = record_digest(64'(jrnl_count + 1), req.in_digest,
                                             req.res_digest, jrnl_head);
                jrnl_in_mem[idx] = req.in_digest;
                jrnl_res_mem[idx] = req.res_digest;
                jrnl_prior_mem[idx] = jrnl_head;
                jrnl_hash_mem[idx] = rsp.rec_hash;
                jrnl_head = rsp.rec_hash;
                jrnl_count = jrnl_count + 1;
            end
        end else begin
            if (req.rd_seq == '0 || req.rd_seq > jrnl_count) begin
                rsp.status = ST_BAD_SEQ;
            end else begin
                idx = req.rd_seq - 1;
                rsp.stored_in = jrnl_in_mem[idx];
                rsp.stored_res = jrnl_res_mem[idx];
                rsp.prior = jrnl_prior_mem[idx];
                rsp.rec_hash = jrnl_hash_mem[idx];
                if (record_digest(64'(req.rd_seq), rsp.stored_in, rsp.stored_res,
                                  rsp.prior) == rsp.rec_hash) begin
                    rsp.seq = SEQ_OUT_W'(req.rd_seq);
                end else begin
                    rsp.status = ST_MISMATCH;
                end
            end
        end
        rsp.total = SEQ_OUT_W'(jrnl_count);
        rsp.head = jrnl_head;
        return rsp;
    endfunction

    task automatic queue_append(input logic [HASH_W-1:0] in_dig,
                                input logic [HASH_W-1:0] res_dig);
        journal_req_t req;
        req.kind = REQ_APPEND;
        req.in_digest = in_dig;
        req.res_digest = res_dig;
        req.rd_seq = RSEQ_W'($urandom);
        pending_requests.push_back(req);
        if (queued_appends < JOURNAL_DEPTH) begin
            queued_appends++;
        end
    endtask

    task automatic queue_read(input logic [RSEQ_W-1:0] seq);
        journal_req_t req;
        req.kind = REQ_READ;
        req.in_digest = {$urandom, $urandom};
        req.res_digest = {$urandom, $urandom};
        req.rd_seq = seq;
        pending_requests.push_back(req);
    endtask

    // random read sequence: mostly stored records, plus zero, boundaries and far misses
    function automatic logic [RSEQ_W-1:0] pick_read_seq();
        int unsigned c;
        c = queued_appends;
        case ($urandom_range(0, 9))
            0: return '0;
            1: return RSEQ_W'(c + 1);
            2: return RSEQ_W'($urandom_range(c + 1, (1 << RSEQ_W) - 1));
            3: return RSEQ_W'(c);
            4: return RSEQ_W'(1);
            default: begin
                if (c == 0) begin
                    return RSEQ_W'($urandom);
                end
                return RSEQ_W'($urandom_range(1, c));
            end
        endcase
    endfunction

    // hold until every queued request has been sent and answered
    task automatic wait_for_drain();
        do begin
            @(negedge aclk);
        end while (pending_requests.size() != 0 || s_valid || expected_responses.size() != 0);
    endtask

    task automatic check_field(input string name, input logic [HASH_W-1:0] want,
                               input logic [HASH_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatch_count++;
        end
    endtask

    // stimulus and end of run
    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // empty journal: every read is out of range
        queue_read('0);
        queue_read(RSEQ_W'(1));
        queue_read('1);
        // digest extremes
        queue_append('0, '0);
        queue_append('1, '1);
        queue_append({$urandom, $urandom}, {$urandom, $urandom});
        queue_read(RSEQ_W'(1));
        queue_read(RSEQ_W'(2));
        queue_read(RSEQ_W'(3));
        queue_read(RSEQ_W'(4));
        queue_read('0);
        queue_read('1);
        queue_append('1, '0);
        queue_append('0, '1);
        queue_read(RSEQ_W'(5));
        queue_read(RSEQ_W'(6));
        wait_for_drain();

        // random mix; appends dominate until the journal fills, then full and reads
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(0, 99) < ((queued_appends < JOURNAL_DEPTH) ? 70 : 30)) begin
                case ($urandom_range(0, 15))
                    0: queue_append('0, {$urandom, $urandom});
                    1: queue_append({$urandom, $urandom}, '1);
                    default: queue_append({$urandom, $urandom}, {$urandom, $urandom});
                endcase
            end else begin
                queue_read(pick_read_seq());
            end
            // occasionally let the journal go fully idle between chunks
            if ((n % CHUNK_ITEMS) == CHUNK_ITEMS - 1 && $urandom_range(0, 1) == 1) begin
                wait_for_drain();
            end
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && expected_responses.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // request driver: bursts of random length separated by random gaps
    int unsigned burst_left = 1;
    int unsigned gap_left = 0;

    always @(posedge aclk) begin : request_driver
        journal_req_t req;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            // transfer on the request channel: predict its response
            if (s_valid && s_ready) begin
                req.kind = req_t'(s_req_type);
                req.in_digest = s_input_digest;
                req.res_digest = s_result_digest;
                req.rd_seq = s_read_sequence;
                expected_responses.push_back(journal_apply(req));
            end
            // next request once the channel is free
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    req = pending_requests.pop_front();
                    s_req_type <= req.kind;
                    s_input_digest <= req.in_digest;
                    s_result_digest <= req.res_digest;
                    s_read_sequence <= req.rd_seq;
                    s_valid <= 1'b1;
                    burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 24);
                        case ($urandom_range(0, 3))
                            0: gap_left = 0;
                            1, 2: gap_left = $urandom_range(1, 6);
                            default: gap_left = $urandom_range(7, 40);
                        endcase
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // response monitor with its own back-pressure pattern
    int unsigned sink_phase = 0;
    int unsigned sink_mode = 0;

    always @(posedge aclk) begin : response_monitor
        journal_resp_t want;
        logic          take_next;
        if (m_valid && m_ready) begin
            if (expected_responses.size() == 0) begin
                $error("unexpected response transfer: status %0d seq %0d",
                       m_status, m_seq_number);
                mismatch_count++;
            end else begin
                want = expected_responses.pop_front();
                check_field("status", 64'(want.status), 64'(m_status));
                check_field("seq_number", 64'(want.seq), 64'(m_seq_number));
                check_field("record_hash", want.rec_hash, m_record_hash);
                check_field("prior_hash", want.prior, m_prior_hash);
                check_field("stored_input_digest", want.stored_in, m_stored_input_digest);
                check_field("stored_result_digest", want.stored_res, m_stored_result_digest);
                check_field("entry_total", 64'(want.total), 64'(m_entry_total));
                check_field("head_hash", want.head, m_head_hash);
            end
        end
        // stall pattern switches style whenever the phase counter wraps
        sink_phase++;
        if (sink_phase == 97) begin
            sink_phase = 0;
            sink_mode = $urandom_range(0, 3);
        end
        case (sink_mode)
            0: take_next = 1'b1;
            1: take_next = ($urandom_range(0, 3) != 0);
            2: take_next = ((sink_phase % 5) == 0);
            default: take_next = $urandom_range(0, 1);
        endcase
        m_ready <= take_next;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

endmodule
